### hw/rtl/ofd_pkg.sv
// Shared constants, types and helpers of the odometry frame decoder.
package ofd_pkg;

    localparam int BYTE_W          = 8;
    localparam int GAIN_W          = 16;
    localparam int OUT_W           = 32;
    localparam int PROD_W          = BYTE_W + GAIN_W;
    localparam int WINDOW_DEPTH    = 10;
    localparam int ACC_WIDTH_DEF   = 32;
    localparam int QUEUE_DEPTH_DEF = 4;
    localparam int NUM_REGS        = 6;
    localparam int ADDR_W          = 5;
    localparam int DATA_W          = 32;
    localparam int REG_IDX_W       = 3;

    // Byte offsets of the frame inside the window, oldest byte first.
    localparam int OFS_HEAD = 0;
    localparam int OFS_X    = 1;
    localparam int OFS_Y    = 2;
    localparam int OFS_ROT  = 3;
    localparam int OFS_STAT = 4;
    localparam int OFS_CHI  = 5;
    localparam int OFS_CLO  = 6;

    localparam logic [BYTE_W-1:0] SYNC_HEAD  = 8'd254;
    localparam logic [BYTE_W-1:0] SYNC_TAIL  = 8'd255;
    localparam logic [BYTE_W-1:0] STATUS_RUN = 8'd100;
    localparam logic [BYTE_W-1:0] STEP_BIAS  = 8'd128;

    localparam logic [GAIN_W-1:0] GAIN_X_POS_RST   = 16'd48705;
    localparam logic [GAIN_W-1:0] GAIN_X_NEG_RST   = 16'd21596;
    localparam logic [GAIN_W-1:0] GAIN_Y_POS_RST   = 16'd51284;
    localparam logic [GAIN_W-1:0] GAIN_Y_NEG_RST   = 16'd40414;
    localparam logic [GAIN_W-1:0] GAIN_ROT_POS_RST = 16'd18126;
    localparam logic [GAIN_W-1:0] GAIN_ROT_NEG_RST = 16'd17186;

    typedef enum logic [REG_IDX_W-1:0] {
        REG_GAIN_X_POS   = 3'd0,
        REG_GAIN_X_NEG   = 3'd1,
        REG_GAIN_Y_POS   = 3'd2,
        REG_GAIN_Y_NEG   = 3'd3,
        REG_GAIN_ROT_POS = 3'd4,
        REG_GAIN_ROT_NEG = 3'd5
    } t_reg_idx;

    typedef struct packed {
        logic [BYTE_W-1:0] raw_x;
        logic [BYTE_W-1:0] raw_y;
        logic [BYTE_W-1:0] raw_rot;
        logic [BYTE_W-1:0] status;
        logic [BYTE_W-1:0] compass_hi;
        logic [BYTE_W-1:0] compass_lo;
    } t_frame;

    typedef struct packed {
        logic [GAIN_W-1:0] x_pos;
        logic [GAIN_W-1:0] x_neg;
        logic [GAIN_W-1:0] y_pos;
        logic [GAIN_W-1:0] y_neg;
        logic [GAIN_W-1:0] rot_pos;
        logic [GAIN_W-1:0] rot_neg;
    } t_gains;

    typedef struct packed {
        logic full;
        logic empty;
    } t_q_status;

    // Distance of a biased byte from the bias point.
    function automatic logic [BYTE_W-1:0] step_mag(input logic [BYTE_W-1:0] raw);
        step_mag = (raw >= STEP_BIAS) ? (raw - STEP_BIAS) : (STEP_BIAS - raw);
    endfunction

endpackage

### hw/rtl/ofd_front.sv
// Front part: byte window and frame recognition.
module ofd_front (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  logic                      i_push,
    input  logic [ofd_pkg::BYTE_W-1:0] i_rx_byte,
    input  logic                      i_q_full,
    output logic                      o_full,
    output logic                      o_frame_valid,
    output ofd_pkg::t_frame           o_frame
);

    logic [ofd_pkg::BYTE_W-1:0] r_window [ofd_pkg::WINDOW_DEPTH];
    logic [ofd_pkg::BYTE_W-1:0] n_window [ofd_pkg::WINDOW_DEPTH];
    logic                       accept;

    assign o_full = i_q_full;
    assign accept = i_push && !i_q_full;

    assign o_frame_valid = accept && (r_window[ofd_pkg::OFS_HEAD] == ofd_pkg::SYNC_HEAD)
                           && (i_rx_byte == ofd_pkg::SYNC_TAIL);

    assign o_frame.raw_x      = r_window[ofd_pkg::OFS_X];
    assign o_frame.raw_y      = r_window[ofd_pkg::OFS_Y];
    assign o_frame.raw_rot    = r_window[ofd_pkg::OFS_ROT];
    assign o_frame.status     = r_window[ofd_pkg::OFS_STAT];
    assign o_frame.compass_hi = r_window[ofd_pkg::OFS_CHI];
    assign o_frame.compass_lo = r_window[ofd_pkg::OFS_CLO];

    always_comb begin
        for (int i = 0; i < ofd_pkg::WINDOW_DEPTH - 1; i++) begin
            n_window[i] = accept ? r_window[i+1] : r_window[i];
        end
        n_window[ofd_pkg::WINDOW_DEPTH-1] = accept ? i_rx_byte
                                                   : r_window[ofd_pkg::WINDOW_DEPTH-1];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < ofd_pkg::WINDOW_DEPTH; i++) begin
                r_window[i] <= '0;
            end
        end else begin
            r_window <= n_window;
        end
    end

endmodule

### hw/rtl/ofd_fifo.sv
// Short frame queue between the front and back parts.
module ofd_fifo #(
    parameter int DEPTH = ofd_pkg::QUEUE_DEPTH_DEF
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_push,
    input  ofd_pkg::t_frame    i_data,
    input  logic               i_pop,
    output ofd_pkg::t_frame    o_data,
    output ofd_pkg::t_q_status o_status
);

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);

    ofd_pkg::t_frame r_mem [DEPTH];
    logic [PTR_W-1:0] r_wr_ptr;
    logic [PTR_W-1:0] r_rd_ptr;
    logic [CNT_W-1:0] r_count;
    logic [PTR_W-1:0] n_wr_ptr;
    logic [PTR_W-1:0] n_rd_ptr;
    logic [CNT_W-1:0] n_count;
    logic             do_push;
    logic             do_pop;

    assign o_status.full  = (r_count == CNT_W'(DEPTH));
    assign o_status.empty = (r_count == '0);
    assign o_data         = r_mem[r_rd_ptr];

    assign do_push = i_push && !o_status.full;
    assign do_pop  = i_pop && !o_status.empty;

    always_comb begin
        n_wr_ptr = r_wr_ptr;
        n_rd_ptr = r_rd_ptr;
        n_count  = r_count;
        if (do_push) begin
            n_wr_ptr = (r_wr_ptr == PTR_W'(DEPTH - 1)) ? '0 : r_wr_ptr + 1'b1;
        end
        if (do_pop) begin
            n_rd_ptr = (r_rd_ptr == PTR_W'(DEPTH - 1)) ? '0 : r_rd_ptr + 1'b1;
        end
        case ({do_push, do_pop})
            2'b10:   n_count = r_count + 1'b1;
            2'b01:   n_count = r_count - 1'b1;
            default: n_count = r_count;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_mem[r_wr_ptr] <= i_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            r_wr_ptr <= n_wr_ptr;
            r_rd_ptr <= n_rd_ptr;
            r_count  <= n_count;
        end
    end

endmodule

### hw/rtl/ofd_back.sv
// Back part: gain scaling, accumulation and the result register.
module ofd_back #(
    parameter int ACC_WIDTH = ofd_pkg::ACC_WIDTH_DEF
) (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  ofd_pkg::t_frame            i_q_data,
    input  logic                       i_q_empty,
    output logic                       o_q_pop,
    input  ofd_pkg::t_gains            i_gains,
    input  logic                       i_pop,
    output logic                       o_empty,
    output logic [ofd_pkg::OUT_W-1:0]  o_odom_x,
    output logic [ofd_pkg::OUT_W-1:0]  o_odom_y,
    output logic [ofd_pkg::OUT_W-1:0]  o_odom_rot,
    output logic [ofd_pkg::BYTE_W-1:0] o_step_x,
    output logic [ofd_pkg::BYTE_W-1:0] o_step_y,
    output logic [ofd_pkg::BYTE_W-1:0] o_step_rot,
    output logic [ofd_pkg::GAIN_W-1:0] o_compass,
    output logic                       o_stop
);

    localparam int PW = ofd_pkg::PROD_W;
    localparam int BW = ofd_pkg::BYTE_W;
    localparam int GW = ofd_pkg::GAIN_W;

    // Multiply stage
    logic              r_s1_valid;
    ofd_pkg::t_frame   r_s1_frame;
    logic [PW-1:0]     r_s1_prod_x;
    logic [PW-1:0]     r_s1_prod_y;
    logic [PW-1:0]     r_s1_prod_rot;
    logic [GW-1:0]     gain_x;
    logic [GW-1:0]     gain_y;
    logic [GW-1:0]     gain_rot;
    logic              s1_adv;

    // Result stage
    logic              r_out_valid;
    ofd_pkg::t_frame   r_out_frame;
    logic [ACC_WIDTH-1:0] r_acc_x;
    logic [ACC_WIDTH-1:0] r_acc_y;
    logic [ACC_WIDTH-1:0] r_acc_rot;
    logic [ACC_WIDTH-1:0] delta_x;
    logic [ACC_WIDTH-1:0] delta_y;
    logic [ACC_WIDTH-1:0] delta_rot;

    function automatic logic [ACC_WIDTH-1:0] signed_step(input logic [PW-1:0]     prod,
                                                         input logic [BW-1:0] raw);
        logic [BW-1:0] mag;
        mag = prod[PW-1:GW];
        signed_step = (raw < ofd_pkg::STEP_BIAS) ? (ACC_WIDTH'(0) - ACC_WIDTH'(mag))
                                                 : ACC_WIDTH'(mag);
    endfunction

    assign s1_adv  = r_s1_valid && (!r_out_valid || i_pop);
    assign o_q_pop = !i_q_empty && (!r_s1_valid || s1_adv);

    // x and y use the positive gain only above the bias; rotation from the bias up.
    assign gain_x   = (i_q_data.raw_x > ofd_pkg::STEP_BIAS) ? i_gains.x_pos : i_gains.x_neg;
    assign gain_y   = (i_q_data.raw_y > ofd_pkg::STEP_BIAS) ? i_gains.y_pos : i_gains.y_neg;
    assign gain_rot = (i_q_data.raw_rot >= ofd_pkg::STEP_BIAS) ? i_gains.rot_pos
                                                               : i_gains.rot_neg;

    always_ff @(posedge i_clk) begin
        if (o_q_pop) begin
            r_s1_frame    <= i_q_data;
            r_s1_prod_x   <= PW'(ofd_pkg::step_mag(i_q_data.raw_x)) * PW'(gain_x);
            r_s1_prod_y   <= PW'(ofd_pkg::step_mag(i_q_data.raw_y)) * PW'(gain_y);
            r_s1_prod_rot <= PW'(ofd_pkg::step_mag(i_q_data.raw_rot)) * PW'(gain_rot);
        end
        if (s1_adv) begin
            r_out_frame <= r_s1_frame;
        end
    end

    assign delta_x   = signed_step(r_s1_prod_x, r_s1_frame.raw_x);
    assign delta_y   = signed_step(r_s1_prod_y, r_s1_frame.raw_y);
    assign delta_rot = signed_step(r_s1_prod_rot, r_s1_frame.raw_rot);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid  <= 1'b0;
            r_out_valid <= 1'b0;
            r_acc_x     <= '0;
            r_acc_y     <= '0;
            r_acc_rot   <= '0;
        end else begin
            if (o_q_pop) begin
                r_s1_valid <= 1'b1;
            end else if (s1_adv) begin
                r_s1_valid <= 1'b0;
            end
            if (s1_adv) begin
                r_out_valid <= 1'b1;
                r_acc_x     <= r_acc_x + delta_x;
                r_acc_y     <= r_acc_y + delta_y;
                r_acc_rot   <= r_acc_rot + delta_rot;
            end else if (i_pop) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    generate
        if (ACC_WIDTH >= ofd_pkg::OUT_W) begin : g_trunc
            assign o_odom_x   = r_acc_x[ofd_pkg::OUT_W-1:0];
            assign o_odom_y   = r_acc_y[ofd_pkg::OUT_W-1:0];
            assign o_odom_rot = r_acc_rot[ofd_pkg::OUT_W-1:0];
        end else begin : g_sext
            assign o_odom_x   = {{(ofd_pkg::OUT_W-ACC_WIDTH){r_acc_x[ACC_WIDTH-1]}}, r_acc_x};
            assign o_odom_y   = {{(ofd_pkg::OUT_W-ACC_WIDTH){r_acc_y[ACC_WIDTH-1]}}, r_acc_y};
            assign o_odom_rot = {{(ofd_pkg::OUT_W-ACC_WIDTH){r_acc_rot[ACC_WIDTH-1]}},
                                 r_acc_rot};
        end
    endgenerate

    assign o_empty    = !r_out_valid;
    assign o_step_x   = r_out_frame.raw_x - ofd_pkg::STEP_BIAS;
    assign o_step_y   = r_out_frame.raw_y - ofd_pkg::STEP_BIAS;
    assign o_step_rot = r_out_frame.raw_rot - ofd_pkg::STEP_BIAS;
    assign o_compass  = {r_out_frame.compass_hi, r_out_frame.compass_lo};
    assign o_stop     = (r_out_frame.status != ofd_pkg::STATUS_RUN);

endmodule

### hw/rtl/odometry_frame_decoder.sv
// Top level of the odometry frame decoder.
//
// Input queue side: one serial byte per transfer (push while full is low).
// Every byte shifts into a ten-byte window; when the oldest window byte is
// 254 and the new byte is 255 the eleven bytes form a frame, and that frame
// yields exactly one result. Other bytes yield nothing.
// Result queue side: a result sits on the o_ ports while empty is low and
// leaves on a transfer with pop high.
// Throughput: one byte per cycle while full is low, and one result per cycle while pop is held high.
// A closing byte passes through the queue write, the gain multiply and the
// accumulate into the result register before its result is visible; a
// stall on the result side can hold it in the queue.
// A frame queue of QUEUE_DEPTH entries sits between recognition and the
// multiply/accumulate part; when the receiver stalls, frames collect there
// and full rises once it is full, stalling the byte side.
// Reset (synchronous, active low) clears the window, the accumulators and
// both queues and loads the six gain registers with their defaults.
// Gains are 16-bit Q0.16 values at APB byte addresses 0, 4, ... 20.
module odometry_frame_decoder #(
    parameter int ACC_WIDTH   = ofd_pkg::ACC_WIDTH_DEF,
    parameter int QUEUE_DEPTH = ofd_pkg::QUEUE_DEPTH_DEF
) (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       push,
    output logic                       full,
    input  logic [ofd_pkg::BYTE_W-1:0] i_rx_byte,
    output logic                       empty,
    input  logic                       pop,
    output logic [ofd_pkg::OUT_W-1:0]  o_odom_x,
    output logic [ofd_pkg::OUT_W-1:0]  o_odom_y,
    output logic [ofd_pkg::OUT_W-1:0]  o_odom_rot,
    output logic [ofd_pkg::BYTE_W-1:0] o_step_x,
    output logic [ofd_pkg::BYTE_W-1:0] o_step_y,
    output logic [ofd_pkg::BYTE_W-1:0] o_step_rot,
    output logic [ofd_pkg::GAIN_W-1:0] o_compass,
    output logic                       o_stop,
    input  logic                       psel,
    input  logic                       penable,
    input  logic                       pwrite,
    input  logic [ofd_pkg::ADDR_W-1:0] paddr,
    input  logic [ofd_pkg::DATA_W-1:0] pwdata,
    output logic [ofd_pkg::DATA_W-1:0] prdata,
    output logic                       pready
);

    ofd_pkg::t_gains    r_gains;
    ofd_pkg::t_frame    frame;
    ofd_pkg::t_frame    q_data;
    ofd_pkg::t_q_status q_status;
    logic               frame_valid;
    logic               q_pop;
    logic               cfg_wr;
    logic [ofd_pkg::REG_IDX_W-1:0] reg_idx;
    logic [ofd_pkg::GAIN_W-1:0]    rd_gain;
    logic [ofd_pkg::GAIN_W-1:0]    wr_gain;

    assign pready  = 1'b1;
    assign cfg_wr  = psel && penable && pwrite && pready;
    assign reg_idx = paddr[ofd_pkg::ADDR_W-1:2];
    assign wr_gain = pwdata[ofd_pkg::GAIN_W-1:0];

    always_comb begin
        case (reg_idx)
            ofd_pkg::REG_GAIN_X_POS:   rd_gain = r_gains.x_pos;
            ofd_pkg::REG_GAIN_X_NEG:   rd_gain = r_gains.x_neg;
            ofd_pkg::REG_GAIN_Y_POS:   rd_gain = r_gains.y_pos;
            ofd_pkg::REG_GAIN_Y_NEG:   rd_gain = r_gains.y_neg;
            ofd_pkg::REG_GAIN_ROT_POS: rd_gain = r_gains.rot_pos;
            ofd_pkg::REG_GAIN_ROT_NEG: rd_gain = r_gains.rot_neg;
            default:                   rd_gain = '0;
        endcase
    end

    assign prdata = ofd_pkg::DATA_W'(rd_gain);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_gains.x_pos   <= ofd_pkg::GAIN_X_POS_RST;
            r_gains.x_neg   <= ofd_pkg::GAIN_X_NEG_RST;
            r_gains.y_pos   <= ofd_pkg::GAIN_Y_POS_RST;
            r_gains.y_neg   <= ofd_pkg::GAIN_Y_NEG_RST;
            r_gains.rot_pos <= ofd_pkg::GAIN_ROT_POS_RST;
            r_gains.rot_neg <= ofd_pkg::GAIN_ROT_NEG_RST;
        end else if (cfg_wr) begin
            case (reg_idx)
                ofd_pkg::REG_GAIN_X_POS:   r_gains.x_pos   <= wr_gain;
                ofd_pkg::REG_GAIN_X_NEG:   r_gains.x_neg   <= wr_gain;
                ofd_pkg::REG_GAIN_Y_POS:   r_gains.y_pos   <= wr_gain;
                ofd_pkg::REG_GAIN_Y_NEG:   r_gains.y_neg   <= wr_gain;
                ofd_pkg::REG_GAIN_ROT_POS: r_gains.rot_pos <= wr_gain;
                ofd_pkg::REG_GAIN_ROT_NEG: r_gains.rot_neg <= wr_gain;
                default:                   r_gains         <= r_gains;
            endcase
        end
    end

    ofd_front u_front (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_push        (push),
        .i_rx_byte     (i_rx_byte),
        .i_q_full      (q_status.full),
        .o_full        (full),
        .o_frame_valid (frame_valid),
        .o_frame       (frame)
    );

    ofd_fifo #(
        .DEPTH (QUEUE_DEPTH)
    ) u_fifo (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_push   (frame_valid),
        .i_data   (frame),
        .i_pop    (q_pop),
        .o_data   (q_data),
        .o_status (q_status)
    );

    ofd_back #(
        .ACC_WIDTH (ACC_WIDTH)
    ) u_back (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_q_data   (q_data),
        .i_q_empty  (q_status.empty),
        .o_q_pop    (q_pop),
        .i_gains    (r_gains),
        .i_pop      (pop),
        .o_empty    (empty),
        .o_odom_x   (o_odom_x),
        .o_odom_y   (o_odom_y),
        .o_odom_rot (o_odom_rot),
        .o_step_x   (o_step_x),
        .o_step_y   (o_step_y),
        .o_step_rot (o_step_rot),
        .o_compass  (o_compass),
        .o_stop     (o_stop)
    );

endmodule

### hw/rtl/ofd_checker.sv
// Port-level checks of the odometry frame decoder, bound to the top level.
module ofd_checker (
    input logic                       i_clk,
    input logic                       i_rst_n,
    input logic                       empty,
    input logic                       pop,
    input logic [ofd_pkg::OUT_W-1:0]  o_odom_x,
    input logic [ofd_pkg::BYTE_W-1:0] o_step_x,
    input logic [ofd_pkg::GAIN_W-1:0] o_compass,
    input logic                       psel,
    input logic                       penable,
    input logic                       pwrite,
    input logic [ofd_pkg::ADDR_W-1:0] paddr,
    input logic [ofd_pkg::DATA_W-1:0] pwdata,
    input logic [ofd_pkg::DATA_W-1:0] prdata
);

    // No result survives reset.
    a_reset_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> empty)
        else $error("result present after reset");

    // A stalled result holds.
    a_stall_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (!empty && !pop) |=> (!empty && $stable(o_odom_x) && $stable(o_compass)))
        else $error("stalled result changed");

    // A zero x step leaves the x accumulator where the previous result had it.
    a_zero_step: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (!empty && pop) ##1 (!empty && o_step_x == '0) |-> o_odom_x == $past(o_odom_x))
        else $error("zero x step moved x odometry");

    // A gain write reads back as its low 16 bits.
    a_cfg_readback: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (psel && penable && pwrite && paddr[ofd_pkg::ADDR_W-1:2] < 3'd6)
        ##1 (paddr == $past(paddr))
        |-> prdata == ofd_pkg::DATA_W'($past(pwdata[ofd_pkg::GAIN_W-1:0])))
        else $error("gain register read back wrong");

endmodule

bind odometry_frame_decoder ofd_checker u_ofd_checker (.*);

### dv/tb_odometry_frame_decoder.sv
// Self-checking testbench for the odometry frame decoder: frame decode, gains, back-pressure.
`timescale 1ns / 1ps

module tb_odometry_frame_decoder;

    localparam int STALL_LIMIT   = 2000;
    localparam int SETTLE_CYCLES = 8;
    localparam int HOLD_CYCLES   = 150;
    localparam int PHASES        = 6;
    localparam int UNITS         = 9;

    localparam int OUT_W  = ofd_pkg::OUT_W;
    localparam int BYTE_W = ofd_pkg::BYTE_W;
    localparam int GAIN_W = ofd_pkg::GAIN_W;
    localparam int ADDR_W = ofd_pkg::ADDR_W;
    localparam int DATA_W = ofd_pkg::DATA_W;

    typedef struct packed {
        logic [OUT_W-1:0]  odom_x;
        logic [OUT_W-1:0]  odom_y;
        logic [OUT_W-1:0]  odom_rot;
        logic [BYTE_W-1:0] step_x;
        logic [BYTE_W-1:0] step_y;
        logic [BYTE_W-1:0] step_rot;
        logic [GAIN_W-1:0] compass;
        logic              stop;
    } t_odom_result;

    logic               i_clk     = 1'b0;
    logic               i_rst_n   = 1'b0;
    logic               push      = 1'b0;
    logic [BYTE_W-1:0]  i_rx_byte = '0;
    logic               pop       = 1'b0;
    logic               psel      = 1'b0;
    logic               penable   = 1'b0;
    logic               pwrite    = 1'b0;
    logic [ADDR_W-1:0]  paddr     = '0;
    logic [DATA_W-1:0]  pwdata    = '0;

    logic               full;
    logic               empty;
    logic [OUT_W-1:0]   o_odom_x;
    logic [OUT_W-1:0]   o_odom_y;
    logic [OUT_W-1:0]   o_odom_rot;
    logic [BYTE_W-1:0]  o_step_x;
    logic [BYTE_W-1:0]  o_step_y;
    logic [BYTE_W-1:0]  o_step_rot;
    logic [GAIN_W-1:0]  o_compass;
    logic               o_stop;
    logic [DATA_W-1:0]  prdata;
    logic               pready;

    // Predictor state
    logic [BYTE_W-1:0]  rx_window [ofd_pkg::WINDOW_DEPTH];
    logic [OUT_W-1:0]   acc_x;
    logic [OUT_W-1:0]   acc_y;
    logic [OUT_W-1:0]   acc_rot;
    logic [GAIN_W-1:0]  gain_reg [ofd_pkg::NUM_REGS];
    t_odom_result       pending_frames [$];

    int err_count      = 0;
    int idle_cycles    = 0;
    int tx_gap_max     = 9;
    int rx_gap_max     = 9;
    int rx_hold_cycles = 0;

    odometry_frame_decoder u_top (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .push       (push),
        .full       (full),
        .i_rx_byte  (i_rx_byte),
        .empty      (empty),
        .pop        (pop),
        .o_odom_x   (o_odom_x),
        .o_odom_y   (o_odom_y),
        .o_odom_rot (o_odom_rot),
        .o_step_x   (o_step_x),
        .o_step_y   (o_step_y),
        .o_step_rot (o_step_rot),
        .o_compass  (o_compass),
        .o_stop     (o_stop),
        .psel       (psel),
        .penable    (penable),
        .pwrite     (pwrite),
        .paddr      (paddr),
        .pwdata     (pwdata),
        .prdata     (prdata),
        .pready     (pready)
    );

    always begin
        #1 i_clk = 1'b1;
        #1 i_clk = 1'b0;
    end

    // Stall watchdog: cycles without any transfer on either side
    always @(posedge i_clk) begin
        if ((push && !full) || (pop && !empty)) begin
            idle_cycles = 0;
        end else begin
            idle_cycles = idle_cycles + 1;
        end
        if (idle_cycles >= STALL_LIMIT) begin
            $display("Verification failed");
            $finish;
        end
    end

    function automatic logic [OUT_W-1:0] scale_step(input logic [BYTE_W-1:0] raw,
                                                    input logic use_pos,
                                                    input logic [GAIN_W-1:0] g_pos,
                                                    input logic [GAIN_W-1:0] g_neg);
        logic [GAIN_W-1:0] g;
        logic [OUT_W-1:0]  mag;
        logic [OUT_W-1:0]  prod;
        g = use_pos ? g_pos : g_neg;
        if (raw >= ofd_pkg::STEP_BIAS) begin
            mag = OUT_W'(raw - ofd_pkg::STEP_BIAS);
        end else begin
            mag = OUT_W'(ofd_pkg::STEP_BIAS - raw);
        end
        // truncate the magnitude, then restore the sign
        prod = (mag * OUT_W'(g)) >> GAIN_W;
        return (raw >= ofd_pkg::STEP_BIAS) ? prod : -prod;
    endfunction

    function void clear_decoder_model();
        for (int i = 0; i < ofd_pkg::WINDOW_DEPTH; i++) rx_window[i] = '0;
        acc_x   = '0;
        acc_y   = '0;
        acc_rot = '0;
        gain_reg[ofd_pkg::REG_GAIN_X_POS]   = ofd_pkg::GAIN_X_POS_RST;
        gain_reg[ofd_pkg::REG_GAIN_X_NEG]   = ofd_pkg::GAIN_X_NEG_RST;
        gain_reg[ofd_pkg::REG_GAIN_Y_POS]   = ofd_pkg::GAIN_Y_POS_RST;
        gain_reg[ofd_pkg::REG_GAIN_Y_NEG]   = ofd_pkg::GAIN_Y_NEG_RST;
        gain_reg[ofd_pkg::REG_GAIN_ROT_POS] = ofd_pkg::GAIN_ROT_POS_RST;
        gain_reg[ofd_pkg::REG_GAIN_ROT_NEG] = ofd_pkg::GAIN_ROT_NEG_RST;
    endfunction

    function void decode_byte(input logic [BYTE_W-1:0] b);
        t_odom_result      r;
        logic [BYTE_W-1:0] rx;
        logic [BYTE_W-1:0] ry;
        logic [BYTE_W-1:0] rt;
        rx = rx_window[ofd_pkg::OFS_X];
        ry = rx_window[ofd_pkg::OFS_Y];
        rt = rx_window[ofd_pkg::OFS_ROT];
        if (rx_window[ofd_pkg::OFS_HEAD] == ofd_pkg::SYNC_HEAD && b == ofd_pkg::SYNC_TAIL) begin
            acc_x = acc_x + scale_step(rx, rx > ofd_pkg::STEP_BIAS,
                                       gain_reg[ofd_pkg::REG_GAIN_X_POS],
                                       gain_reg[ofd_pkg::REG_GAIN_X_NEG]);
            acc_y = acc_y + scale_step(ry, ry > ofd_pkg::STEP_BIAS,
                                       gain_reg[ofd_pkg::REG_GAIN_Y_POS],
                                       gain_reg[ofd_pkg::REG_GAIN_Y_NEG]);
            // rotation puts the zero step on the positive gain
            acc_rot = acc_rot + scale_step(rt, rt >= ofd_pkg::STEP_BIAS,
                                           gain_reg[ofd_pkg::REG_GAIN_ROT_POS],
                                           gain_reg[ofd_pkg::REG_GAIN_ROT_NEG]);
            r.odom_x   = acc_x;
            r.odom_y   = acc_y;
            r.odom_rot = acc_rot;
            r.step_x   = rx - ofd_pkg::STEP_BIAS;
            r.step_y   = ry - ofd_pkg::STEP_BIAS;
            r.step_rot = rt - ofd_pkg::STEP_BIAS;
            r.compass  = {rx_window[ofd_pkg::OFS_CHI], rx_window[ofd_pkg::OFS_CLO]};
            r.stop     = (rx_window[ofd_pkg::OFS_STAT] != ofd_pkg::STATUS_RUN);
            pending_frames.push_back(r);
        end
        for (int i = 0; i < ofd_pkg::WINDOW_DEPTH - 1; i++) rx_window[i] = rx_window[i + 1];
        rx_window[ofd_pkg::WINDOW_DEPTH - 1] = b;
    endfunction

    task automatic flag_error(input string what, input logic [31:0] got,
                              input logic [31:0] want);
        $display("mismatch %s: got 0x%08h, want 0x%08h at %0t", what, got, want, $realtime);
        err_count++;
    endtask

    task automatic check_result();
        t_odom_result want;
        if (pending_frames.size() == 0) begin
            flag_error("result with no frame pending", o_odom_x, '0);
            return;
        end
        want = pending_frames.pop_front();
        if (o_odom_x !== want.odom_x)     flag_error("odom_x", o_odom_x, want.odom_x);
        if (o_odom_y !== want.odom_y)     flag_error("odom_y", o_odom_y, want.odom_y);
        if (o_odom_rot !== want.odom_rot) flag_error("odom_rot", o_odom_rot, want.odom_rot);
        if (o_step_x !== want.step_x)     flag_error("step_x", o_step_x, want.step_x);
        if (o_step_y !== want.step_y)     flag_error("step_y", o_step_y, want.step_y);
        if (o_step_rot !== want.step_rot) flag_error("step_rot", o_step_rot, want.step_rot);
        if (o_compass !== want.compass)   flag_error("compass", o_compass, want.compass);
        if (o_stop !== want.stop)         flag_error("stop", o_stop, want.stop);
    endtask

    initial begin : result_sink
        int gap;
        wait (i_rst_n === 1'b1);
        forever begin
            if (rx_hold_cycles > 0) begin
                pop <= 1'b0;
                repeat (rx_hold_cycles) @(posedge i_clk);
                rx_hold_cycles = 0;
            end
            gap = $urandom_range(rx_gap_max, 0);
            if (gap > 0) begin
                pop <= 1'b0;
                repeat (gap) @(posedge i_clk);
            end
            pop <= 1'b1;
            do @(posedge i_clk); while (empty);
            check_result();
        end
    end

    task automatic send_byte(input logic [BYTE_W-1:0] b);
        int gap;
        gap = $urandom_range(tx_gap_max, 0);
        if (gap > 0) begin
            push <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        push      <= 1'b1;
        i_rx_byte <= b;
        do @(posedge i_clk); while (full);
        decode_byte(b);
    endtask

    task automatic write_reg(input int unsigned idx, input logic [DATA_W-1:0] value);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= ADDR_W'(idx * 4);
        pwdata  <= value;
        @(posedge i_clk);
        penable <= 1'b1;
        do @(posedge i_clk); while (!pready);
        psel    <= 1'b0;
        penable <= 1'b0;
        if (idx < ofd_pkg::NUM_REGS) gain_reg[idx] = value[GAIN_W-1:0];
        // leave the bus idle before the next write
        @(posedge i_clk);
    endtask

    // Stop sending, let every pending frame come out, then let the pipe settle
    task automatic wait_for_drain();
        push <= 1'b0;
        while (pending_frames.size() != 0) @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    function automatic logic [BYTE_W-1:0] pick_step_byte();
        case ($urandom_range(7, 0))
            0:       return 8'd0;
            1:       return 8'd127;
            2:       return ofd_pkg::STEP_BIAS;
            3:       return 8'd129;
            4:       return 8'd255;
            default: return 8'($urandom);
        endcase
    endfunction

    task automatic send_frame(input logic [BYTE_W-1:0] x, input logic [BYTE_W-1:0] y,
                              input logic [BYTE_W-1:0] rot, input logic [BYTE_W-1:0] status,
                              input logic [BYTE_W-1:0] chi, input logic [BYTE_W-1:0] clo);
        send_byte(ofd_pkg::SYNC_HEAD);
        send_byte(x);
        send_byte(y);
        send_byte(rot);
        send_byte(status);
        send_byte(chi);
        send_byte(clo);
        for (int i = ofd_pkg::OFS_CLO + 1; i < ofd_pkg::WINDOW_DEPTH; i++) begin
            send_byte(8'($urandom));
        end
        send_byte(ofd_pkg::SYNC_TAIL);
    endtask

    task automatic send_random_frame();
        send_frame(pick_step_byte(), pick_step_byte(), pick_step_byte(),
                   $urandom_range(1, 0) ? ofd_pkg::STATUS_RUN : 8'($urandom),
                   8'($urandom), 8'($urandom));
    endtask

    task automatic send_noise();
        int n;
        n = $urandom_range(6, 1);
        repeat (n) begin
            case ($urandom_range(3, 0))
                0:       send_byte(ofd_pkg::SYNC_HEAD);
                1:       send_byte(ofd_pkg::SYNC_TAIL);
                default: send_byte(8'($urandom));
            endcase
        end
    endtask

    // Head and part of a body, never closed in place
    task automatic send_broken_frame();
        int n;
        n = $urandom_range(ofd_pkg::WINDOW_DEPTH - 1, 1);
        send_byte(ofd_pkg::SYNC_HEAD);
        repeat (n) send_byte(pick_step_byte());
    endtask

    task automatic test_directed_frames();
        logic [BYTE_W-1:0] script [21];
        // lone tail into a zero window, then two frames where the second head
        // sits in the ignored bytes of the first and its x byte is the first tail
        script = '{ofd_pkg::SYNC_TAIL,
                   ofd_pkg::SYNC_HEAD, 8'd0, 8'd255, ofd_pkg::STEP_BIAS, ofd_pkg::STATUS_RUN,
                   8'hFF, 8'h00, 8'h11, 8'h22, ofd_pkg::SYNC_HEAD, ofd_pkg::SYNC_TAIL,
                   8'd0, 8'd127, ofd_pkg::STATUS_RUN + 8'd1, 8'h00, 8'hFF,
                   8'h33, 8'h44, 8'h55, ofd_pkg::SYNC_TAIL};
        foreach (script[i]) send_byte(script[i]);
        wait_for_drain();
    endtask

    task automatic test_gain_extremes();
        // upper data bits must be dropped
        for (int r = 0; r < ofd_pkg::NUM_REGS; r++) write_reg(r, {16'($urandom), 16'hFFFF});
        repeat (12) send_random_frame();
        wait_for_drain();
        for (int r = 0; r < ofd_pkg::NUM_REGS; r++) begin
            write_reg(r, {16'($urandom) | 16'h1, 16'h0000});
        end
        repeat (8) send_random_frame();
        wait_for_drain();
    endtask

    task automatic test_unknown_registers();
        for (int r = 0; r < ofd_pkg::NUM_REGS; r++) write_reg(r, $urandom);
        write_reg(ofd_pkg::NUM_REGS, $urandom);
        write_reg(ofd_pkg::NUM_REGS + 1, $urandom);
        repeat (6) send_random_frame();
        wait_for_drain();
    endtask

    task automatic test_backpressure();
        tx_gap_max     = 0;
        rx_hold_cycles = HOLD_CYCLES;
        repeat (10) send_random_frame();
        tx_gap_max = 9;
        wait_for_drain();
    endtask

    task automatic test_random_phases();
        for (int phase = 0; phase < PHASES; phase++) begin
            if (phase == 0) begin
                tx_gap_max = 0;
                rx_gap_max = 0;
            end else begin
                tx_gap_max = $urandom_range(1, 0) ? 9 : 0;
                rx_gap_max = $urandom_range(1, 0) ? 9 : 0;
            end
            for (int r = 0; r < ofd_pkg::NUM_REGS; r++) write_reg(r, $urandom);
            repeat (UNITS) begin
                case ($urandom_range(9, 0))
                    0:       send_noise();
                    1:       send_broken_frame();
                    default: send_random_frame();
                endcase
            end
            wait_for_drain();
        end
        tx_gap_max = 9;
        rx_gap_max = 9;
    endtask

    initial begin
        clear_decoder_model();
        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        test_directed_frames();
        test_gain_extremes();
        test_unknown_registers();
        test_backpressure();
        test_random_phases();
        wait_for_drain();
        if (err_count == 0) begin
            $display("Verification passed");
        end else begin
            $display("Verification failed");
        end
        $finish;
    end

endmodule
